// File: rtl/i2da_pkg.sv
package i2da_pkg;

    localparam int BIN_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int CHAR_W     = 7;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int DLEFT_W    = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

endpackage

// File: rtl/int32_to_decimal_ascii.sv
// Converts one 32-bit value per item to its decimal ASCII text, most significant
// digit first, with no leading zeros; s_op selects unsigned or signed reading, and
// a negative signed value is preceded by '-'. The last character of each value has
// m_last set. An item is loaded, runs through the shift-add-3 converter (one
// input bit per cycle), has its leading zero digits dropped until the first digit
// is found, gets a minus sign if negative, and then sends its digits one by one
// while the output side keeps up, stalling when it does not. The ten digit
// positions are always walked. One item is in work at a time; a new item is taken
// as soon as the last character of the previous one sits in the output register.
module int32_to_decimal_ascii
    import i2da_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [BIN_W-1:0]  s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_code,
    output logic              m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DLEFT_W-1:0]   dleft_reg, dleft_next;
    logic                 neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    m_char_code_reg, m_char_code_next;
    logic                 m_last_reg, m_last_next;

    logic                 out_free;
    logic                 in_neg;
    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   top_digit;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last      = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_neg    = (s_op == OP_SIGNED) && s_value[BIN_W-1];
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // Each BCD digit of 5 or more gets 3 added before the shift doubles it.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        bin_next         = bin_reg;
        bcd_next         = bcd_reg;
        cnt_next         = cnt_reg;
        dleft_next       = dleft_reg;
        neg_next         = neg_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next   = in_neg;
                    bin_next   = in_neg ? (~s_value + BIN_W'(1)) : s_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BIN_W - 1)) begin
                    dleft_next = DLEFT_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // A zero value keeps its final digit.
                if (top_digit == '0 && dleft_reg != DLEFT_W'(1)) begin
                    bcd_next   = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dleft_next = dleft_reg - DLEFT_W'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = CHAR_MINUS;
                    m_last_next      = 1'b0;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = CHAR_ZERO + CHAR_W'(top_digit);
                    m_last_next      = (dleft_reg == DLEFT_W'(1));
                    bcd_next         = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dleft_next       = dleft_reg - DLEFT_W'(1);
                    if (dleft_reg == DLEFT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg         <= bin_next;
        bcd_reg         <= bcd_next;
        cnt_reg         <= cnt_next;
        dleft_reg       <= dleft_next;
        neg_reg         <= neg_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg      <= m_last_next;
    end

    a_conv_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV |=> state_reg == ST_CONV || state_reg == ST_SKIP)
        else $error("converter left its shift phase early");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_code_reg == CHAR_MINUS ||
                         (m_char_code_reg >= CHAR_ZERO &&
                          m_char_code_reg <= CHAR_ZERO + CHAR_W'(9))))
        else $error("character is neither a digit nor a minus sign");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CONV && cnt_reg == '0)
        else $error("accepted item did not start conversion");

    a_bcd_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> top_digit <= DIGIT_W'(9) && dleft_reg != '0)
        else $error("invalid BCD digit or digit count at emit");

    a_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SIGN && out_free |=> m_valid_reg && !m_last_reg)
        else $error("minus sign was not emitted ahead of the digits");

endmodule
